// ----- design/aff2d_pkg.sv -----
`timescale 1ns / 1ps
package aff2d_pkg;

   localparam logic [2:0] OP_IDENTITY = 3'd0;
   localparam logic [2:0] OP_SCALE    = 3'd1;
   localparam logic [2:0] OP_SHIFT    = 3'd2;
   localparam logic [2:0] OP_ROTATE   = 3'd3;
   localparam logic [2:0] OP_SCALAR   = 3'd4;
   localparam logic [2:0] OP_POINT    = 3'd5;

   localparam int CORDIC_FRAC = 24;
   localparam int XY_W = 28;
   localparam int Z_W = 34;
   localparam logic signed [XY_W-1:0] CORDIC_GAIN = 28'sd10188014;

   typedef enum logic [2:0] {
      ST_IDLE, ST_ROT, ST_MUL, ST_ACC, ST_SAT, ST_COPY, ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      CS_IDLE, CS_MOD, CS_FOLD, CS_ITER, CS_OUT
   } cordic_state_type;

   typedef struct packed {
      logic mul_en;
      logic acc_en;
      logic acc_clr;
   } mac_ctrl_type;

   // atan(2^-i) in degrees, 24 fraction bits
   function automatic logic signed [Z_W-1:0] atan_deg(input logic [4:0] idx);
      logic signed [Z_W-1:0] v;
      case (idx)
         5'd0:  v = 34'sd754974720;
         5'd1:  v = 34'sd445687602;
         5'd2:  v = 34'sd235489089;
         5'd3:  v = 34'sd119537938;
         5'd4:  v = 34'sd60000934;
         5'd5:  v = 34'sd30029717;
         5'd6:  v = 34'sd15018523;
         5'd7:  v = 34'sd7509719;
         5'd8:  v = 34'sd3754917;
         5'd9:  v = 34'sd1877466;
         5'd10: v = 34'sd938734;
         5'd11: v = 34'sd469367;
         5'd12: v = 34'sd234684;
         5'd13: v = 34'sd117342;
         5'd14: v = 34'sd58671;
         5'd15: v = 34'sd29335;
         5'd16: v = 34'sd14668;
         5'd17: v = 34'sd7334;
         5'd18: v = 34'sd3667;
         5'd19: v = 34'sd1833;
         5'd20: v = 34'sd917;
         5'd21: v = 34'sd458;
         5'd22: v = 34'sd229;
         5'd23: v = 34'sd115;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

// ----- design/aff2d_mac.sv -----
`timescale 1ns / 1ps
module aff2d_mac import aff2d_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic                clock,
   input  mac_ctrl_type        ctrl,
   input  logic signed [31:0]  op_a,
   input  logic signed [31:0]  op_b,
   output logic signed [31:0]  sat_val,
   output logic                sat_flag
);

   localparam int ACC_W = 66 - FRAC_BITS;
   localparam logic signed [63:0] RND = 64'sd1 <<< (FRAC_BITS - 1);
   localparam logic signed [ACC_W-1:0] SMAX = ACC_W'(64'sd2147483647);
   localparam logic signed [ACC_W-1:0] SMIN = ACC_W'(-64'sd2147483648);

   logic signed [63:0]      prod_ff;
   logic signed [63:0]      rnd_full;
   logic signed [ACC_W-1:0] acc_ff;
   logic signed [ACC_W-1:0] acc_in;

   always_comb begin
      rnd_full = (prod_ff + RND) >>> FRAC_BITS;
      acc_in   = (ctrl.acc_clr ? '0 : acc_ff) + rnd_full[ACC_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (ctrl.mul_en) begin
         prod_ff <= op_a * op_b;
      end
      if (ctrl.acc_en) begin
         acc_ff <= acc_in;
      end
   end

   always_comb begin
      sat_flag = 1'b0;
      sat_val  = acc_ff[31:0];
      if (acc_ff > SMAX) begin
         sat_flag = 1'b1;
         sat_val  = 32'sh7fffffff;
      end else if (acc_ff < SMIN) begin
         sat_flag = 1'b1;
         sat_val  = 32'sh80000000;
      end
   end

endmodule

// ----- design/aff2d_cordic.sv -----
`timescale 1ns / 1ps
module aff2d_cordic import aff2d_pkg::*; #(
   parameter int FRAC_BITS    = 16,
   parameter int CORDIC_STEPS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [31:0] angle,
   output logic               done,
   output logic signed [31:0] cos_val,
   output logic signed [31:0] sin_val
);

   localparam int SH_W = 40;
   localparam int R_W = 35;
   localparam logic [SH_W-1:0] FULL = SH_W'(360) << FRAC_BITS;
   localparam logic signed [R_W-1:0] FULL_R    = R_W'(360) <<< FRAC_BITS;
   localparam logic signed [R_W-1:0] HALF_R    = R_W'(180) <<< FRAC_BITS;
   localparam logic signed [R_W-1:0] QUARTER_R = R_W'(90) <<< FRAC_BITS;
   localparam int MOD_STEPS = 34 - $clog2(64'(360) << FRAC_BITS);
   localparam int MAX_STEPS = (MOD_STEPS > CORDIC_STEPS) ? MOD_STEPS : CORDIC_STEPS;
   localparam int CNT_W = $clog2(MAX_STEPS + 1);
   localparam int CSH = CORDIC_FRAC - FRAC_BITS;
   localparam logic signed [XY_W-1:0] RND_C = XY_W'((1 << CSH) >> 1);

   cordic_state_type        state_ff, state_in;
   logic [CNT_W-1:0]        cnt_ff;
   logic [32:0]             rem_ff;
   logic                    sgn_ff;
   logic                    neg_ff;
   logic signed [XY_W-1:0]  x_ff, y_ff;
   logic signed [Z_W-1:0]   z_ff;
   logic signed [31:0]      cos_ff, sin_ff;
   logic                    done_ff;

   logic [SH_W-1:0]         full_sh;
   logic signed [R_W-1:0]   r0, r1;
   logic                    fold_neg;
   logic signed [XY_W-1:0]  dx, dy, xr, yr;
   logic signed [Z_W-1:0]   at;

   always_comb begin
      full_sh = FULL << cnt_ff;
      r0 = sgn_ff ? -$signed({2'b00, rem_ff}) : $signed({2'b00, rem_ff});
      if (r0 < 0) begin
         r0 = r0 + FULL_R;
      end
      if (r0 > HALF_R) begin
         r0 = r0 - FULL_R;
      end
      fold_neg = 1'b0;
      r1 = r0;
      if (r0 > QUARTER_R) begin
         r1 = r0 - HALF_R;
         fold_neg = 1'b1;
      end else if (r0 < -QUARTER_R) begin
         r1 = r0 + HALF_R;
         fold_neg = 1'b1;
      end
      dx = y_ff >>> cnt_ff;
      dy = x_ff >>> cnt_ff;
      at = atan_deg(5'(cnt_ff));
      xr = (x_ff + RND_C) >>> CSH;
      yr = (y_ff + RND_C) >>> CSH;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         CS_IDLE: if (start) state_in = CS_MOD;
         CS_MOD:  if (cnt_ff == '0) state_in = CS_FOLD;
         CS_FOLD: state_in = CS_ITER;
         CS_ITER: if (cnt_ff == CNT_W'(CORDIC_STEPS - 1)) state_in = CS_OUT;
         CS_OUT:  state_in = CS_IDLE;
         default: state_in = CS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= (state_ff == CS_OUT);
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         CS_IDLE: begin
            sgn_ff <= angle[31];
            rem_ff <= angle[31] ? 33'(-{angle[31], angle}) : {1'b0, angle};
            cnt_ff <= CNT_W'(MOD_STEPS - 1);
         end
         CS_MOD: begin
            // restoring reduction, one multiple of the full turn per cycle
            if ({7'b0, rem_ff} >= full_sh) begin
               rem_ff <= 33'({7'b0, rem_ff} - full_sh);
            end
            cnt_ff <= cnt_ff - 1'b1;
         end
         CS_FOLD: begin
            x_ff   <= CORDIC_GAIN;
            y_ff   <= '0;
            z_ff   <= Z_W'(r1 <<< CSH);
            neg_ff <= fold_neg;
            cnt_ff <= '0;
         end
         CS_ITER: begin
            if (!z_ff[Z_W-1]) begin
               x_ff <= x_ff - dx;
               y_ff <= y_ff + dy;
               z_ff <= z_ff - at;
            end else begin
               x_ff <= x_ff + dx;
               y_ff <= y_ff - dy;
               z_ff <= z_ff + at;
            end
            cnt_ff <= cnt_ff + 1'b1;
         end
         CS_OUT: begin
            cos_ff <= 32'(neg_ff ? -xr : xr);
            sin_ff <= 32'(neg_ff ? -yr : yr);
         end
         default: begin
            cnt_ff <= '0;
         end
      endcase
   end

   assign done    = done_ff;
   assign cos_val = cos_ff;
   assign sin_val = sin_ff;

endmodule

// ----- design/affine_transform_2d_engine.sv -----
`timescale 1ns / 1ps
// Channel  Dir  Ports                                          Transfer when
// req      in   req_operation, req_value_a, req_value_b        req_valid & !req_stall
// rsp      out  rsp_result_x/y/w, rsp_is_point, rsp_saturated  rsp_valid & !rsp_stall
//
// One command at a time; the shared 32x32 multiplier sets the pace: each matrix
// entry takes three products, each a multiply and an accumulate step, plus a
// saturate step. Rotate first runs angle reduction, then the CORDIC iterations.
// Synchronous reset restores the identity matrix. req_stall is high while busy
// and while a finished result cannot move into the output register.
module affine_transform_2d_engine import aff2d_pkg::*; #(
   parameter int FRAC_BITS    = 16,
   parameter int CORDIC_STEPS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_operation,
   input  logic signed [31:0] req_value_a,
   input  logic signed [31:0] req_value_b,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_result_x,
   output logic signed [31:0] rsp_result_y,
   output logic signed [31:0] rsp_result_w,
   output logic               rsp_is_point,
   output logic               rsp_saturated
);

   localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

   state_type          state_ff, state_in;
   logic [2:0]         op_ff;
   logic [1:0]         i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic signed [31:0] m_ff   [9];
   logic signed [31:0] t_ff   [9];
   logic signed [31:0] t_load [9];
   logic signed [31:0] tmp_ff [9];
   logic signed [31:0] res_ff [3];
   logic               flag_ff;
   logic               rsp_valid_ff;
   logic signed [31:0] rx_ff, ry_ff, rw_ff;
   logic               pt_ff, sat_ff;

   logic               accept, load_out, cordic_start, cordic_done, is_pt;
   logic [3:0]         m_idx, t_idx, o_idx;
   logic [1:0]         j_max;
   mac_ctrl_type       mac_ctrl;
   logic signed [31:0] sat_val, cos_val, sin_val;
   logic               sat_flag;

   assign accept       = req_valid && !req_stall;
   assign is_pt        = (op_ff == OP_POINT);
   assign j_max        = is_pt ? 2'd0 : 2'd2;
   assign m_idx        = 4'(i_ff) * 4'd3 + 4'(k_ff);
   assign t_idx        = 4'(k_ff) * 4'd3 + 4'(j_ff);
   assign o_idx        = 4'(i_ff) * 4'd3 + 4'(j_ff);
   assign load_out     = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);
   assign cordic_start = accept && (req_operation == OP_ROTATE);

   aff2d_cordic #(
      .FRAC_BITS    (FRAC_BITS),
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cordic_start),
      .angle   (req_value_a),
      .done    (cordic_done),
      .cos_val (cos_val),
      .sin_val (sin_val)
   );

   aff2d_mac #(
      .FRAC_BITS (FRAC_BITS)
   ) u_mac (
      .clock    (clock),
      .ctrl     (mac_ctrl),
      .op_a     (m_ff[m_idx]),
      .op_b     (t_ff[t_idx]),
      .sat_val  (sat_val),
      .sat_flag (sat_flag)
   );

   always_comb begin
      state_in  = state_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      k_in      = k_ff;
      mac_ctrl  = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            i_in = '0;
            j_in = '0;
            k_in = '0;
            if (req_valid) begin
               case (req_operation)
                  OP_ROTATE: state_in = ST_ROT;
                  OP_SCALE, OP_SHIFT, OP_SCALAR, OP_POINT: state_in = ST_MUL;
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_ROT: begin
            if (cordic_done) state_in = ST_MUL;
         end
         ST_MUL: begin
            mac_ctrl.mul_en = 1'b1;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            mac_ctrl.acc_en  = 1'b1;
            mac_ctrl.acc_clr = (k_ff == 2'd0);
            if (k_ff == 2'd2) begin
               k_in = '0;
               state_in = ST_SAT;
            end else begin
               k_in = k_ff + 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_SAT: begin
            state_in = ST_MUL;
            if (j_ff == j_max) begin
               j_in = '0;
               if (i_ff == 2'd2) begin
                  state_in = is_pt ? ST_DONE : ST_COPY;
               end else begin
                  i_in = i_ff + 1'b1;
               end
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         ST_COPY: state_in = ST_DONE;
         ST_DONE: begin
            if (load_out) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // transform operand for the command on the request port
   always_comb begin
      for (int n = 0; n < 9; n++) begin
         t_load[n] = (n == 0 || n == 4 || n == 8) ? ONE : '0;
      end
      case (req_operation)
         OP_SCALE: begin
            t_load[0] = req_value_a;
            t_load[4] = req_value_b;
         end
         OP_SHIFT: begin
            t_load[2] = req_value_a;
            t_load[5] = req_value_b;
         end
         OP_SCALAR: begin
            t_load[0] = req_value_a;
            t_load[4] = req_value_a;
            t_load[8] = req_value_a;
         end
         OP_POINT: begin
            // column 0 carries (x, y, 1)
            t_load[0] = req_value_a;
            t_load[3] = req_value_b;
            t_load[6] = ONE;
         end
         default: begin
            t_load[1] = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int n = 0; n < 9; n++) begin
            m_ff[n] <= (n == 0 || n == 4 || n == 8) ? ONE : '0;
         end
      end else begin
         state_ff <= state_in;
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (accept && req_operation == OP_IDENTITY) begin
            for (int n = 0; n < 9; n++) begin
               m_ff[n] <= (n == 0 || n == 4 || n == 8) ? ONE : '0;
            end
         end else if (state_ff == ST_COPY) begin
            for (int n = 0; n < 9; n++) begin
               m_ff[n] <= tmp_ff[n];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      i_ff <= i_in;
      j_ff <= j_in;
      k_ff <= k_in;
      if (accept) begin
         op_ff   <= req_operation;
         flag_ff <= 1'b0;
         for (int n = 0; n < 9; n++) begin
            t_ff[n] <= t_load[n];
         end
      end
      if (state_ff == ST_ROT && cordic_done) begin
         t_ff[0] <= cos_val;
         t_ff[1] <= -sin_val;
         t_ff[3] <= sin_val;
         t_ff[4] <= cos_val;
      end
      if (state_ff == ST_SAT) begin
         flag_ff <= flag_ff | sat_flag;
         if (is_pt) begin
            res_ff[i_ff] <= sat_val;
         end else begin
            tmp_ff[o_idx] <= sat_val;
         end
      end
      if (load_out) begin
         rx_ff  <= is_pt ? res_ff[0] : '0;
         ry_ff  <= is_pt ? res_ff[1] : '0;
         rw_ff  <= is_pt ? res_ff[2] : '0;
         pt_ff  <= is_pt;
         sat_ff <= flag_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_result_x  = rx_ff;
   assign rsp_result_y  = ry_ff;
   assign rsp_result_w  = rw_ff;
   assign rsp_is_point  = pt_ff;
   assign rsp_saturated = sat_ff;

`ifndef SYNTH
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("block took a command while busy");

   a_matrix_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_is_point) |->
      (rsp_result_x == 0 && rsp_result_y == 0 && rsp_result_w == 0))
      else $error("matrix command returned nonzero point");

   a_cordic_in_rot: assert property (@(posedge clock) disable iff (reset)
      cordic_done |-> state_ff == ST_ROT)
      else $error("CORDIC finished outside rotate");
`endif

endmodule

// ----- verif/affine_transform_2d_engine_tb.sv -----
`timescale 1ns / 1ps
module affine_transform_2d_engine_tb;
   import aff2d_pkg::*;

   localparam logic [2:0] OP_RSVD_6 = 3'd6;
   localparam logic [2:0] OP_RSVD_7 = 3'd7;
   localparam int FRAC = 16;
   localparam int STEPS = 16;
   localparam longint ONE = 64'sd1 << FRAC;
   localparam int STALL_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 150;

   typedef struct {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] w;
      logic               is_point;
      logic               saturated;
   } xform_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [2:0] req_operation = OP_IDENTITY;
   logic signed [31:0] req_value_a = '0;
   logic signed [31:0] req_value_b = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [31:0] rsp_result_x, rsp_result_y, rsp_result_w;
   logic rsp_is_point, rsp_saturated;

   logic signed [31:0] model_matrix[9];
   xform_result_type expected_results[$];
   bit idle_on = 1'b1;
   int fail_count = 0;
   int quiet_cycles = 0;

   always #5 clock = ~clock;

   affine_transform_2d_engine u_dut (.*);

   function automatic logic signed [31:0] clip32(longint v, inout bit f);
      if (v > 64'sd2147483647) begin
         f = 1'b1;
         return 32'sh7fffffff;
      end
      if (v < -64'sd2147483648) begin
         f = 1'b1;
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

   function automatic longint fx_mul(longint a, longint b);
      return (a * b + (64'sd1 << (FRAC - 1))) >>> FRAC;
   endfunction

   function automatic longint cordic_round(longint v);
      return (v + (64'sd1 << (CORDIC_FRAC - FRAC - 1))) >>> (CORDIC_FRAC - FRAC);
   endfunction

   task automatic identity_matrix();
      for (int i = 0; i < 9; i++) model_matrix[i] = '0;
      model_matrix[0] = ONE;
      model_matrix[4] = ONE;
      model_matrix[8] = ONE;
   endtask

   task automatic post_mult(longint t[9], inout bit f);
      logic signed [31:0] tmp[9];
      longint acc;
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++) begin
            acc = 0;
            for (int k = 0; k < 3; k++)
               acc += fx_mul(longint'(model_matrix[i*3+k]), t[k*3+j]);
            tmp[i*3+j] = clip32(acc, f);
         end
      model_matrix = tmp;
   endtask

   task automatic sin_cos_deg(longint ang, output longint c, output longint s);
      longint r, x, y, z, dx, dy;
      bit neg;
      r = ang % (360 * ONE);
      neg = 1'b0;
      if (r < 0) r += 360 * ONE;
      if (r > 180 * ONE) r -= 360 * ONE;
      if (r > 90 * ONE) begin
         r -= 180 * ONE;
         neg = 1'b1;
      end else if (r < -90 * ONE) begin
         r += 180 * ONE;
         neg = 1'b1;
      end
      x = CORDIC_GAIN;
      y = 0;
      z = r <<< (CORDIC_FRAC - FRAC);
      for (int i = 0; i < STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= atan_deg(5'(i));
         end else begin
            x += dx; y -= dy; z += atan_deg(5'(i));
         end
      end
      x = cordic_round(x);
      y = cordic_round(y);
      c = neg ? -x : x;
      s = neg ? -y : y;
   endtask

   // advance the model matrix and return the result this command produces
   task automatic apply_command(logic [2:0] op, logic signed [31:0] va,
                                logic signed [31:0] vb, output xform_result_type r);
      longint t[9];
      longint a, b, c, s;
      bit f;
      a = va;
      b = vb;
      f = 1'b0;
      r = '{default: '0};
      for (int i = 0; i < 9; i++) t[i] = 0;
      t[0] = ONE; t[4] = ONE; t[8] = ONE;
      case (op)
         OP_IDENTITY: identity_matrix();
         OP_SCALE: begin
            t[0] = a; t[4] = b;
            post_mult(t, f);
         end
         OP_SHIFT: begin
            t[2] = a; t[5] = b;
            post_mult(t, f);
         end
         OP_ROTATE: begin
            sin_cos_deg(a, c, s);
            t[0] = c; t[1] = -s; t[3] = s; t[4] = c;
            post_mult(t, f);
         end
         OP_SCALAR:
            for (int i = 0; i < 9; i++)
               model_matrix[i] = clip32(fx_mul(longint'(model_matrix[i]), a), f);
         OP_POINT: begin
            r.is_point = 1'b1;
            r.x = clip32(fx_mul(model_matrix[0], a) + fx_mul(model_matrix[1], b)
                         + longint'(model_matrix[2]), f);
            r.y = clip32(fx_mul(model_matrix[3], a) + fx_mul(model_matrix[4], b)
                         + longint'(model_matrix[5]), f);
            r.w = clip32(fx_mul(model_matrix[6], a) + fx_mul(model_matrix[7], b)
                         + longint'(model_matrix[8]), f);
         end
         default: ;
      endcase
      r.saturated = f;
   endtask

   task automatic send_cmd(logic [2:0] op, logic signed [31:0] va, logic signed [31:0] vb);
      xform_result_type r;
      @(negedge clock);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_value_a <= va;
      req_value_b <= vb;
      do @(posedge clock); while (req_stall);
      apply_command(op, va, vb, r);
      expected_results.push_back(r);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   function automatic logic signed [31:0] q16(int whole);
      return whole <<< FRAC;
   endfunction

   // map extreme points through the reset matrix
   task automatic test_point_extremes();
      send_cmd(OP_POINT, 32'sh7fffffff, 32'sh80000000);
      send_cmd(OP_POINT, 32'sh80000000, 32'sh7fffffff);
      send_cmd(OP_POINT, 0, 0);
      send_cmd(OP_POINT, 32'shffffffff, 32'sh00000001);
   endtask

   task automatic test_matrix_ops();
      send_cmd(OP_SCALE, q16(3), -q16(2));
      send_cmd(OP_POINT, q16(5), q16(7));
      send_cmd(OP_SHIFT, q16(10), -q16(20));
      send_cmd(OP_POINT, q16(1), q16(1));
      send_cmd(OP_SCALAR, q16(2) + 32'sh8000, 0);
      send_cmd(OP_POINT, -q16(4), q16(9));
      // drive entries into clipping both ways
      send_cmd(OP_SCALAR, 32'sh7fffffff, 0);
      send_cmd(OP_POINT, 32'sh7fffffff, 32'sh7fffffff);
      send_cmd(OP_SCALAR, 32'sh80000000, 0);
      send_cmd(OP_SHIFT, 32'sh80000000, 32'sh7fffffff);
      send_cmd(OP_SCALE, 32'sh80000000, 32'sh7fffffff);
      send_cmd(OP_POINT, 32'sh80000000, 32'sh80000000);
      send_cmd(OP_IDENTITY, 32'sh7fffffff, 32'sh80000000);
   endtask

   task automatic test_rotate_angles();
      send_cmd(OP_ROTATE, q16(90), 0);
      send_cmd(OP_ROTATE, q16(180), 0);
      send_cmd(OP_ROTATE, -q16(180), 0);
      send_cmd(OP_ROTATE, q16(270) + 32'sh4000, 0);
      send_cmd(OP_ROTATE, -q16(91), 0);
      send_cmd(OP_ROTATE, 32'sh7fffffff, 32'sh7fffffff);
      send_cmd(OP_ROTATE, 32'sh80000000, 0);
      send_cmd(OP_POINT, q16(100), -q16(50));
   endtask

   task automatic test_reserved_codes();
      send_cmd(OP_RSVD_6, 32'sh12345678, 32'sh80000000);
      send_cmd(OP_RSVD_7, 32'sh7fffffff, 32'shffffffff);
      send_cmd(OP_POINT, q16(3), q16(4));
   endtask

   function automatic logic signed [31:0] rand_value();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
         default: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh1ffff + 32'sh2000;
      endcase
   endfunction

   task automatic test_random(int count);
      logic [2:0] op;
      logic signed [31:0] va, vb;
      for (int n = 0; n < count; n++) begin
         if (n == count - 150) idle_on = 1'b0;
         case ($urandom_range(0, 19))
            0: op = OP_IDENTITY;
            1, 2: op = OP_SCALE;
            3, 4: op = OP_SHIFT;
            5, 6, 7: op = OP_ROTATE;
            8: op = OP_SCALAR;
            9: op = ($urandom_range(0, 1) != 0) ? OP_RSVD_6 : OP_RSVD_7;
            default: op = OP_POINT;
         endcase
         va = rand_value();
         vb = rand_value();
         if (op == OP_ROTATE && $urandom_range(0, 1) != 0)
            va = 32'($signed($urandom_range(0, 720)) * ONE - 360 * ONE);
         if (op == OP_SCALAR && $urandom_range(0, 3) != 0)
            va = $signed($urandom_range(0, 32'h30000)) - 32'sh18000;
         // keep the matrix in range most of the time
         if (model_matrix[0] == 32'sh7fffffff || model_matrix[0] == 32'sh80000000)
            if ($urandom_range(0, 1) != 0) op = OP_IDENTITY;
         send_cmd(op, va, vb);
         if (n == count / 2) wait_drained();
      end
   endtask

   always @(negedge clock) begin
      if (idle_on && $urandom_range(0, 5) == 0 && !rsp_stall) begin
         rsp_stall <= 1'b1;
         fork
            begin
               repeat ($urandom_range(1, 5)) @(negedge clock);
               rsp_stall <= 1'b0;
            end
         join_none
      end
   end

   always @(posedge clock) begin
      xform_result_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            $display("%0t: result with nothing expected: x=%h y=%h w=%h",
                     $time, rsp_result_x, rsp_result_y, rsp_result_w);
            fail_count++;
         end else begin
            e = expected_results.pop_front();
            if (rsp_result_x !== e.x || rsp_result_y !== e.y || rsp_result_w !== e.w
                || rsp_is_point !== e.is_point || rsp_saturated !== e.saturated) begin
               $display("%0t: mismatch exp x=%h y=%h w=%h pt=%b sat=%b", $time,
                        e.x, e.y, e.w, e.is_point, e.saturated);
               $display("%0t:          got x=%h y=%h w=%h pt=%b sat=%b", $time,
                        rsp_result_x, rsp_result_y, rsp_result_w, rsp_is_point,
                        rsp_saturated);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: timeout, no transfer for %0d cycles", $time, STALL_LIMIT);
         $display("** affine_transform_2d_engine: FAILED **");
         $finish;
      end
   end

   initial begin
      identity_matrix();
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      test_point_extremes();
      test_matrix_ops();
      test_rotate_angles();
      test_reserved_codes();
      test_random(920);
      wait_drained();
      if (fail_count == 0)
         $display("** affine_transform_2d_engine: PASSED **");
      else
         $display("** affine_transform_2d_engine: FAILED **");
      $finish;
   end

endmodule

// ----- sim.f -----
design/aff2d_pkg.sv
design/aff2d_mac.sv
design/aff2d_cordic.sv
design/affine_transform_2d_engine.sv
verif/affine_transform_2d_engine_tb.sv
